### src/ced_pkg.sv
// Shared types and constants for the chunk energy voice detector.
// Holds the decibel threshold table, built at elaboration; depends on nothing.
package ced_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int SQ_W      = 31;
	localparam int SUM_W     = 40;
	localparam int MEAN_W    = 31;
	localparam int LEVEL_W   = 8;
	localparam int SAMPLES_W = 10;

	localparam int DIV_STEPS = SUM_W;

	// mean square is clamped to full scale
	localparam logic [MEAN_W-1:0] FULL_SCALE = MEAN_W'(32'h4000_0000);

	// level reported for a silent chunk
	localparam logic signed [LEVEL_W-1:0] LEVEL_SILENCE = -8'sd96;

	// levels 0 down to -91 have an entry each
	localparam int LVL_ENTRIES = 92;
	localparam int LVL_IDX_W   = $clog2(LVL_ENTRIES);
	localparam int LVL_SEARCH  = LVL_IDX_W;

	localparam logic [MEAN_W-1:0] THRESHOLD_RESET = MEAN_W'(107374);

	typedef logic [LVL_ENTRIES-1:0][MEAN_W-1:0] lvl_tab_t;

	// true when m^10 * p10 >= 2^300
	function automatic logic pow_ge(logic [31:0] m, logic [639:0] p10);
		logic [639:0] a;
		logic [639:0] a2;
		logic [639:0] a4;
		logic [639:0] a8;
		logic [639:0] a10;
		logic [639:0] prod;
		a    = 640'(m);
		a2   = a * a;
		a4   = a2 * a2;
		a8   = a4 * a4;
		a10  = a8 * a2;
		prod = a10 * p10;
		return prod >= (640'(1) << 300);
	endfunction

	// entry j: least mean square whose level is at least -j
	function automatic lvl_tab_t build_lvl_tab();
		lvl_tab_t     tab;
		logic [639:0] p10;
		logic [31:0]  lo;
		logic [31:0]  hi;
		logic [31:0]  mid;
		tab = '0;
		p10 = 640'(1);
		for (int j = 0; j < LVL_ENTRIES; j++) begin
			lo = 32'd1;
			hi = 32'h4000_0000;
			for (int s = 0; s < 31; s++) begin
				if (lo < hi) begin
					mid = (lo + hi) >> 1;
					if (pow_ge(mid, p10)) begin
						hi = mid;
					end else begin
						lo = mid + 32'd1;
					end
				end
			end
			tab[j] = MEAN_W'(lo);
			p10    = p10 * 640'(10);
		end
		return tab;
	endfunction

	localparam lvl_tab_t LVL_TAB = build_lvl_tab();

endpackage

### src/ced_if.sv
// Request channels of the voice detector: samples in, chunk results out,
// threshold writes. Depends on ced_pkg for field widths.
interface ced_sample_if
	import ced_pkg::*;
();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] left_sample;
	logic                       chunk_end;

	modport source (output valid, output left_sample, output chunk_end, input ready);
	modport sink   (input valid, input left_sample, input chunk_end, output ready);
endinterface

interface ced_result_if
	import ced_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic [MEAN_W-1:0]         mean_square;
	logic signed [LEVEL_W-1:0] level_db;
	logic                      voice_active;
	logic                      speech_started;
	logic                      speech_ended;
	logic [SAMPLES_W-1:0]      chunk_samples;

	modport source (
		output valid, output mean_square, output level_db, output voice_active,
		output speech_started, output speech_ended, output chunk_samples,
		input ready
	);
	modport sink (
		input valid, input mean_square, input level_db, input voice_active,
		input speech_started, input speech_ended, input chunk_samples,
		output ready
	);
endinterface

interface ced_cfg_if
	import ced_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [MEAN_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### src/chunk_energy_voice_detector_core.sv
// Chunk energy voice detector: one 16-bit sample per cycle while the queue has
// room, one result per chunk. The closing sample passes the front register, the
// queue, the one-bit-a-cycle divider, the level search (skipped for a silent
// chunk) and the result register. A two-chunk queue lets samples run at one per
// cycle while the back end works, so chunks of 50 samples or more sustain it.
// Reset clears sum, count and voice flag and loads the threshold with 107374.
module chunk_energy_voice_detector_core
	import ced_pkg::*;
#(
	parameter int CHUNK_MAX = 512
) (
	input  logic         clk,
	input  logic         arst_n,
	ced_sample_if.sink   samples,
	ced_result_if.source results,
	ced_cfg_if.sink      cfg
);

	localparam int CNT_W = $clog2(CHUNK_MAX + 1);

	logic              push_valid;
	logic              push_ready;
	logic [SUM_W-1:0]  push_sum;
	logic [CNT_W-1:0]  push_cnt;
	logic              pop_valid;
	logic              pop_ready;
	logic [SUM_W-1:0]  pop_sum;
	logic [CNT_W-1:0]  pop_cnt;
	logic [MEAN_W-1:0] threshold_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
		end else if (cfg.valid && cfg.ready) begin
			threshold_q <= cfg.data;
		end
	end

	ced_front #(
		.CHUNK_MAX (CHUNK_MAX),
		.CNT_W     (CNT_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (samples),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_sum   (push_sum),
		.push_cnt   (push_cnt)
	);

	ced_queue #(
		.CNT_W (CNT_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_sum   (push_sum),
		.push_cnt   (push_cnt),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_sum    (pop_sum),
		.pop_cnt    (pop_cnt)
	);

	ced_back #(
		.CNT_W (CNT_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_sum   (pop_sum),
		.pop_cnt   (pop_cnt),
		.threshold (threshold_q),
		.results   (results)
	);

	// a full queue must hold the sample input
	a_stall_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		(push_valid && !push_ready) |-> !samples.ready)
		else $error("sample accepted while queue full");

	// a popped chunk must take the back end out of idle
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(pop_ready && pop_valid) |=> !pop_ready)
		else $error("back end did not start on a popped chunk");

	a_mean_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> (results.mean_square <= FULL_SCALE))
		else $error("mean square above full scale");

	a_silence_level: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && (results.mean_square == '0)) |-> (results.level_db == LEVEL_SILENCE))
		else $error("silent chunk with wrong level");

endmodule

### src/ced_front.sv
// Front end: squares each sample and accumulates chunk energy and count.
// Hands each closed chunk to the queue. Depends on ced_pkg, ced_sample_if.
module ced_front
	import ced_pkg::*;
#(
	parameter int CHUNK_MAX = 512,
	parameter int CNT_W     = $clog2(CHUNK_MAX + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	ced_sample_if.sink        samples,
	output logic              push_valid,
	input  logic              push_ready,
	output logic [SUM_W-1:0]  push_sum,
	output logic [CNT_W-1:0]  push_cnt
);

	logic                    valid_s1;
	logic [SQ_W-1:0]         sq_s1;
	logic                    end_s1;
	logic [SUM_W-1:0]        sum_q;
	logic [CNT_W-1:0]        cnt_q;

	logic [SAMPLE_W-1:0]     mag;
	logic [SUM_W:0]          sum_add;
	logic [SUM_W-1:0]        sum_next;
	logic [CNT_W-1:0]        cnt_next;
	logic                    close;
	logic                    advance;

	// magnitude of -32768 wraps to 16'h8000, which is still right unsigned
	assign mag      = samples.left_sample[SAMPLE_W-1] ?
		SAMPLE_W'(-samples.left_sample) : SAMPLE_W'(samples.left_sample);
	assign sum_add  = {1'b0, sum_q} + (SUM_W + 1)'(sq_s1);
	assign sum_next = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
	assign cnt_next = cnt_q + CNT_W'(1);
	assign close    = end_s1 || (cnt_next >= CNT_W'(CHUNK_MAX));
	assign advance  = valid_s1 && (!close || push_ready);

	assign samples.ready = !valid_s1 || advance;
	assign push_valid    = valid_s1 && close;
	assign push_sum      = sum_next;
	assign push_cnt      = cnt_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			sum_q    <= '0;
			cnt_q    <= '0;
		end else begin
			if (advance) begin
				if (close) begin
					sum_q <= '0;
					cnt_q <= '0;
				end else begin
					sum_q <= sum_next;
					cnt_q <= cnt_next;
				end
			end
			if (samples.valid && samples.ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			sq_s1  <= SQ_W'(mag) * SQ_W'(mag);
			end_s1 <= samples.chunk_end;
		end
	end

endmodule

### src/ced_queue.sv
// Two-entry queue of closed chunks between front and back end.
// Depends on ced_pkg for the energy sum width.
module ced_queue
	import ced_pkg::*;
#(
	parameter int CNT_W = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  logic [SUM_W-1:0]  push_sum,
	input  logic [CNT_W-1:0]  push_cnt,
	output logic              pop_valid,
	input  logic              pop_ready,
	output logic [SUM_W-1:0]  pop_sum,
	output logic [CNT_W-1:0]  pop_cnt
);

	logic [SUM_W-1:0] sum_q [2];
	logic [CNT_W-1:0] cnt_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       fill_q;
	logic             push;
	logic             pop;

	assign push_ready = (fill_q != 2'd2);
	assign pop_valid  = (fill_q != 2'd0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_sum    = sum_q[rd_ptr_q];
	assign pop_cnt    = cnt_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			sum_q[wr_ptr_q] <= push_sum;
			cnt_q[wr_ptr_q] <= push_cnt;
		end
	end

endmodule

### src/ced_back.sv
// Back end: serial divide for the mean square, binary search of the level
// table, voice decision and the result register. Depends on ced_pkg, ced_result_if.
module ced_back
	import ced_pkg::*;
#(
	parameter int CNT_W = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pop_valid,
	output logic              pop_ready,
	input  logic [SUM_W-1:0]  pop_sum,
	input  logic [CNT_W-1:0]  pop_cnt,
	input  logic [MEAN_W-1:0] threshold,
	ced_result_if.source      results
);

	localparam int STEP_W = $clog2(DIV_STEPS);

	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_LVL, ST_OUT} state_t;

	state_t               state_q;
	logic [STEP_W-1:0]    step_q;
	logic [SUM_W-1:0]     quo_q;
	logic [CNT_W-1:0]     rem_q;
	logic [CNT_W-1:0]     div_q;
	logic [MEAN_W-1:0]    mean_q;
	logic                 zero_q;
	logic [LVL_IDX_W-1:0] lo_q;
	logic [LVL_IDX_W-1:0] hi_q;
	logic                 voice_q;

	logic [CNT_W:0]       rem_sh;
	logic                 q_bit;
	logic [CNT_W-1:0]     rem_next;
	logic [SUM_W-1:0]     quo_next;
	logic [MEAN_W-1:0]    mean_clamp;
	logic [LVL_IDX_W:0]   mid_sum;
	logic [LVL_IDX_W-1:0] mid;
	logic                 active;
	logic                 out_free;

	assign rem_sh   = {rem_q, quo_q[SUM_W-1]};
	assign q_bit    = rem_sh >= {1'b0, div_q};
	assign rem_next = q_bit ? CNT_W'(rem_sh - {1'b0, div_q}) : CNT_W'(rem_sh);
	assign quo_next = {quo_q[SUM_W-2:0], q_bit};

	assign mean_clamp = (quo_next > SUM_W'(FULL_SCALE)) ? FULL_SCALE : MEAN_W'(quo_next);

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[LVL_IDX_W:1];

	assign active    = mean_q > threshold;
	assign out_free  = !results.valid || results.ready;
	assign pop_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			voice_q       <= 1'b0;
			results.valid <= 1'b0;
		end else begin
			if ((state_q == ST_OUT) && out_free) begin
				results.valid <= 1'b1;
			end else if (results.ready) begin
				results.valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						state_q <= (mean_clamp == '0) ? ST_OUT : ST_LVL;
					end
				end
				ST_LVL: begin
					if (lo_q == hi_q) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						voice_q <= active;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				quo_q  <= pop_sum;
				div_q  <= pop_cnt;
				rem_q  <= '0;
				step_q <= '0;
			end
			ST_DIV: begin
				quo_q  <= quo_next;
				rem_q  <= rem_next;
				step_q <= step_q + STEP_W'(1);
				mean_q <= mean_clamp;
				zero_q <= (mean_clamp == '0);
				lo_q   <= '0;
				hi_q   <= LVL_IDX_W'(LVL_ENTRIES - 1);
			end
			ST_LVL: begin
				if (lo_q != hi_q) begin
					// narrow to the least index whose threshold the mean reaches
					if (mean_q >= LVL_TAB[mid]) begin
						hi_q <= mid;
					end else begin
						lo_q <= mid + LVL_IDX_W'(1);
					end
				end
			end
			ST_OUT: begin
				if (out_free) begin
					results.mean_square    <= mean_q;
					results.level_db       <= zero_q ? LEVEL_SILENCE :
						-$signed(LEVEL_W'(lo_q));
					results.voice_active   <= active;
					results.speech_started <= active && !voice_q;
					results.speech_ended   <= !active && voice_q;
					results.chunk_samples  <= SAMPLES_W'(div_q);
				end
			end
			default: ;
		endcase
	end

endmodule
